>>> design/tgcd_pkg.sv
// shared widths, op and register codes, and the vertex record passed between stages
// of the tile geometry command decoder; no dependencies
`default_nettype none

package tgcd_pkg;

    localparam int WORD_W     = 32;
    localparam int OP_W       = 3;
    localparam int CNT_W      = WORD_W - OP_W;
    localparam int COORD_W    = 64;
    localparam int PEN_W      = 32;
    localparam int TILE_W     = 32;
    localparam int ZOOM_W     = 6;
    localparam int EXT_W      = 16;
    localparam int CFG_DATA_W = 32;
    localparam int QUO_W      = 33;
    localparam int DIV_STEPS  = QUO_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [ZOOM_W-1:0] FULL_ZOOM   = ZOOM_W'(32);
    localparam logic [EXT_W-1:0]  EXT_RESET   = EXT_W'(4096);
    // 2^32 div 4096 for the reset register values
    localparam logic [QUO_W-1:0]  QUO_RESET   = QUO_W'(1) << 20;

    localparam logic [OP_W-1:0] OP_MOVE = OP_W'(1);
    localparam logic [OP_W-1:0] OP_LINE = OP_W'(2);

    typedef enum logic [1:0] {
        CFG_ZOOM,
        CFG_COLUMN,
        CFG_ROW,
        CFG_EXTENT
    } t_cfg_idx;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             vertex;
        logic [PEN_W-1:0] pen_x;
        logic [PEN_W-1:0] pen_y;
    } t_vtx;

    // left shift that stands for 2^(32 - zoom); zoom above 32 acts as 32
    function automatic logic [ZOOM_W-1:0] scale_shift(input logic [ZOOM_W-1:0] zoom);
        logic [ZOOM_W-1:0] res;
        if (zoom > FULL_ZOOM) begin
            res = '0;
        end else begin
            res = FULL_ZOOM - zoom;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> design/tgcd_word_if.sv
// input channel of the tile geometry command decoder: one geometry word per beat
// depends on tgcd_pkg
`default_nettype none

interface tgcd_word_if;
    import tgcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] geometry_word;
    logic              feature_start;

    modport source (output valid, output geometry_word, output feature_start, input ready);
    modport sink   (input valid, input geometry_word, input feature_start, output ready);
endinterface

`default_nettype wire

>>> design/tgcd_path_if.sv
// output channel of the tile geometry command decoder: one path item per beat
// depends on tgcd_pkg
`default_nettype none

interface tgcd_path_if;
    import tgcd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           path_op;
    logic signed [COORD_W-1:0] world_x;
    logic signed [COORD_W-1:0] world_y;

    modport source (output valid, output path_op, output world_x, output world_y, input ready);
    modport sink   (input valid, input path_op, input world_x, input world_y, output ready);
endinterface

`default_nettype wire

>>> design/tgcd_div.sv
// restoring divider for the step quotient 2^shift div extent, one quotient bit a cycle
// depends on tgcd_pkg
`default_nettype none

module tgcd_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tgcd_pkg::ZOOM_W-1:0]   i_shift,
    input  wire logic [tgcd_pkg::EXT_W-1:0]    i_extent,
    output logic                               o_busy,
    output logic [tgcd_pkg::QUO_W-1:0]         o_quotient
);
    import tgcd_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [QUO_W-1:0]     r_dvd;
    logic [EXT_W-1:0]     r_dvs;
    logic [EXT_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;

    logic [EXT_W:0] rem_sh;
    logic           fits;

    assign rem_sh = {r_rem, r_dvd[QUO_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_quo <= QUO_RESET;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_STEPS);
            r_dvd <= QUO_W'(1) << i_shift;
            // an extent of zero divides as one
            r_dvs <= (i_extent == '0) ? EXT_W'(1) : i_extent;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            r_dvd <= r_dvd << 1;
            r_rem <= fits ? EXT_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[EXT_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DIV_CNT_W'(DIV_STEPS))
        else $error("divider step count out of range");

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_cnt == DIV_CNT_W'(DIV_STEPS))
        else $error("divider did not load on start");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) && (r_cnt != DIV_CNT_W'(DIV_STEPS)) |-> r_rem < r_dvs)
        else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

>>> design/tgcd_decode.sv
// command decoder: pen position, pair count and op state, and the vertex register
// feeding the scale stages; depends on tgcd_pkg and tgcd_word_if
`default_nettype none

module tgcd_decode (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    tgcd_word_if.sink           i_word,
    input  wire logic           i_hold,
    input  wire logic           i_next_ready,
    output logic                o_valid,
    output tgcd_pkg::t_vtx      o_vtx
);
    import tgcd_pkg::*;

    logic [PEN_W-1:0] r_pen_x, r_pen_y;
    logic [CNT_W-1:0] r_pairs;
    logic [OP_W-1:0]  r_active;
    logic             r_expect_y;
    logic             r_valid;
    t_vtx             r_vtx;

    logic [PEN_W-1:0] n_pen_x, n_pen_y;
    logic [CNT_W-1:0] n_pairs;
    logic [OP_W-1:0]  n_active;
    logic             n_expect_y;

    logic             emit;
    logic             vertex;
    logic [OP_W-1:0]  emit_op;
    logic [OP_W-1:0]  cmd_op;
    logic [CNT_W-1:0] cmd_cnt;
    logic [PEN_W-1:0] delta;
    logic             slot_free;
    logic             fire;

    assign cmd_op  = i_word.geometry_word[OP_W-1:0];
    assign cmd_cnt = i_word.geometry_word[WORD_W-1:OP_W];
    // zigzag decode
    assign delta   = (i_word.geometry_word >> 1) ^ {PEN_W{i_word.geometry_word[0]}};

    assign slot_free    = !r_valid || i_next_ready;
    assign i_word.ready = slot_free && !i_hold;
    assign fire         = i_word.valid && i_word.ready;

    always_comb begin
        n_pen_x    = r_pen_x;
        n_pen_y    = r_pen_y;
        n_pairs    = r_pairs;
        n_active   = r_active;
        n_expect_y = r_expect_y;
        emit       = 1'b0;
        vertex     = 1'b0;
        emit_op    = cmd_op;
        if (i_word.feature_start) begin
            n_pen_x    = '0;
            n_pen_y    = '0;
            n_pairs    = '0;
            n_active   = '0;
            n_expect_y = 1'b0;
        end
        if (n_pairs == '0) begin
            if (cmd_op == OP_MOVE || cmd_op == OP_LINE) begin
                if (cmd_cnt != '0) begin
                    n_active   = cmd_op;
                    n_pairs    = cmd_cnt;
                    n_expect_y = 1'b0;
                end
            end else begin
                emit = 1'b1;
            end
        end else if (!n_expect_y) begin
            n_pen_x    = n_pen_x + delta;
            n_expect_y = 1'b1;
        end else begin
            n_pen_y    = n_pen_y + delta;
            n_expect_y = 1'b0;
            n_pairs    = n_pairs - CNT_W'(1);
            emit       = 1'b1;
            vertex     = 1'b1;
            emit_op    = n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x    <= '0;
            r_pen_y    <= '0;
            r_pairs    <= '0;
            r_active   <= '0;
            r_expect_y <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (fire) begin
                r_pen_x    <= n_pen_x;
                r_pen_y    <= n_pen_y;
                r_pairs    <= n_pairs;
                r_active   <= n_active;
                r_expect_y <= n_expect_y;
            end
            if (slot_free) begin
                r_valid <= fire && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && slot_free) begin
            r_vtx.op     <= emit_op;
            r_vtx.vertex <= vertex;
            r_vtx.pen_x  <= n_pen_x;
            r_vtx.pen_y  <= n_pen_y;
        end
    end

    assign o_valid = r_valid;
    assign o_vtx   = r_vtx;

    a_vertex_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_vtx.vertex |-> r_vtx.op == OP_MOVE || r_vtx.op == OP_LINE)
        else $error("vertex beat carries an op other than move-to or line-to");

    a_y_needs_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_expect_y |-> r_pairs != '0)
        else $error("waiting for a y delta with no pair left");

    a_no_take_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hold |=> $stable(r_pairs) && $stable(r_pen_x) && $stable(r_pen_y))
        else $error("command state moved while the quotient was being formed");

endmodule

`default_nettype wire

>>> design/tgcd_scale.sv
// world coordinate stages: quotient times pen and tile offset registered,
// then the 64-bit sum into the output register; depends on tgcd_pkg and tgcd_path_if
`default_nettype none

module tgcd_scale (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire tgcd_pkg::t_vtx                i_vtx,
    output logic                               o_ready,
    input  wire logic [tgcd_pkg::QUO_W-1:0]    i_quotient,
    input  wire logic [tgcd_pkg::ZOOM_W-1:0]   i_shift,
    input  wire logic [tgcd_pkg::TILE_W-1:0]   i_column,
    input  wire logic [tgcd_pkg::TILE_W-1:0]   i_row,
    tgcd_path_if.source                        o_path
);
    import tgcd_pkg::*;

    logic                r_mul_valid;
    logic [OP_W-1:0]     r_mul_op;
    logic                r_mul_vertex;
    logic [COORD_W-1:0]  r_prod_x, r_prod_y;
    logic [COORD_W-1:0]  r_off_x, r_off_y;

    logic                r_out_valid;
    logic [OP_W-1:0]     r_out_op;
    logic [COORD_W-1:0]  r_out_x, r_out_y;

    logic signed [COORD_W+1:0] mul_x, mul_y;
    logic                      mul_free, out_free;

    // unsigned quotient times sign-extended pen, kept modulo 2^64
    assign mul_x = $signed({1'b0, i_quotient}) * $signed(i_vtx.pen_x);
    assign mul_y = $signed({1'b0, i_quotient}) * $signed(i_vtx.pen_y);

    assign out_free = !r_out_valid || o_path.ready;
    assign mul_free = !r_mul_valid || out_free;
    assign o_ready  = mul_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (mul_free) begin
                r_mul_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_mul_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_free && i_valid) begin
            r_mul_op     <= i_vtx.op;
            r_mul_vertex <= i_vtx.vertex;
            r_prod_x     <= mul_x[COORD_W-1:0];
            r_prod_y     <= mul_y[COORD_W-1:0];
            r_off_x      <= COORD_W'(i_column) << i_shift;
            r_off_y      <= COORD_W'(i_row) << i_shift;
        end
        if (out_free && r_mul_valid) begin
            r_out_op <= r_mul_op;
            r_out_x  <= r_mul_vertex ? r_off_x + r_prod_x : '0;
            r_out_y  <= r_mul_vertex ? r_off_y + r_prod_y : '0;
        end
    end

    assign o_path.valid   = r_out_valid;
    assign o_path.path_op = r_out_op;
    assign o_path.world_x = r_out_x;
    assign o_path.world_y = r_out_y;

    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_valid && !out_free |=> r_mul_valid && $stable(r_prod_x) && $stable(r_mul_op))
        else $error("multiply stage lost a beat while the output was stalled");

    a_nonvertex_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_free && r_mul_valid && !r_mul_vertex |=> r_out_x == '0 && r_out_y == '0)
        else $error("non-vertex beat carries a coordinate");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && mul_free |=> r_mul_valid)
        else $error("taken beat did not reach the multiply stage");

endmodule

`default_nettype wire

>>> design/tile_geometry_command_decoder.sv
// an item passes the vertex, multiply and output registers on its way out
// throughput: one geometry word per cycle, set by the pen update loop, while the
// divider is idle and the output is not stalled; a write to the zoom or extent
// register re-forms the step quotient in a bit-serial divider, which stalls words
// reset (synchronous, active low) loads reset config, quotient 2^20 and an idle pen
`default_nettype none

module tile_geometry_command_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire tgcd_pkg::t_cfg_idx                i_cfg_index,
    input  wire logic [tgcd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    tgcd_word_if.sink                              i_geom,
    tgcd_path_if.source                            o_path
);
    import tgcd_pkg::*;

    logic [ZOOM_W-1:0] r_zoom;
    logic [TILE_W-1:0] r_column;
    logic [TILE_W-1:0] r_row;
    logic [EXT_W-1:0]  r_extent;

    logic              div_start;
    logic              div_busy;
    logic [QUO_W-1:0]  quotient;
    logic [ZOOM_W-1:0] new_zoom;
    logic [EXT_W-1:0]  new_extent;

    logic              vtx_valid;
    t_vtx              vtx;
    logic              scale_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom   <= '0;
            r_column <= '0;
            r_row    <= '0;
            r_extent <= EXT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ZOOM:   r_zoom   <= i_cfg_data[ZOOM_W-1:0];
                CFG_COLUMN: r_column <= i_cfg_data[TILE_W-1:0];
                CFG_ROW:    r_row    <= i_cfg_data[TILE_W-1:0];
                CFG_EXTENT: r_extent <= i_cfg_data[EXT_W-1:0];
                default:    r_zoom   <= r_zoom;
            endcase
        end
    end

    // the divider starts from the values being written
    assign div_start  = i_cfg_we && (i_cfg_index == CFG_ZOOM || i_cfg_index == CFG_EXTENT);
    assign new_zoom   = (i_cfg_index == CFG_ZOOM) ? i_cfg_data[ZOOM_W-1:0] : r_zoom;
    assign new_extent = (i_cfg_index == CFG_EXTENT) ? i_cfg_data[EXT_W-1:0] : r_extent;

    tgcd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_shift    (scale_shift(new_zoom)),
        .i_extent   (new_extent),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    tgcd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (i_geom),
        .i_hold       (div_busy),
        .i_next_ready (scale_ready),
        .o_valid      (vtx_valid),
        .o_vtx        (vtx)
    );

    tgcd_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (vtx_valid),
        .i_vtx      (vtx),
        .o_ready    (scale_ready),
        .i_quotient (quotient),
        .i_shift    (scale_shift(r_zoom)),
        .i_column   (r_column),
        .i_row      (r_row),
        .o_path     (o_path)
    );

    a_div_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> div_busy && !i_geom.ready)
        else $error("quotient not re-formed after a scale register write");

    a_quiet_on_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> !(i_geom.valid && i_geom.ready))
        else $error("word taken while the quotient was being formed");

    a_reset_quotient: assert property (@(posedge i_clk)
        !i_rst_n |=> quotient == QUO_RESET && !div_busy)
        else $error("quotient not at its reset value after reset");

endmodule

`default_nettype wire
